/* design/nhr_pkg.sv */
// ----------------------------------------------------------------------------
// nhr_pkg
// Types and constants shared by the ring step schedule block.
// ----------------------------------------------------------------------------
package nhr_pkg;

  localparam int RS_W      = 7;   // rank_size register width
  localparam int IDX_W     = 6;   // my_index register width
  localparam int STEP_W    = 3;   // step_count / step_number width
  localparam int FW        = 6;   // result rank / slice field width
  localparam int RES_CAP   = 32;  // max results per step
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  typedef enum logic [1:0] {
    REG_RANK_SIZE  = 2'd0,
    REG_MY_INDEX   = 2'd1,
    REG_STEP_COUNT = 2'd2,
    REG_NONE       = 2'd3
  } nhr_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ME,
    ST_DINIT,
    ST_DSHIFT,
    ST_PEER,
    ST_EMIT
  } nhr_state_t;

  typedef struct packed {
    logic load;
    logic rem_shift;
    logic rem_clr;
    logic rem_src_me;
    logic rem_one;
    logic save_me;
    logic save_dmod;
    logic peer;
    logic next_slice;
  } nhr_cmd_t;

  typedef struct packed {
    logic              bad;
    logic [STEP_W-1:0] shift;
    logic              last;
  } nhr_sts_t;

  typedef struct packed {
    logic [FW-1:0] from_rank;
    logic [FW-1:0] to_rank;
    logic [FW-1:0] slice_count;
    logic [FW-1:0] tx_slice;
    logic [FW-1:0] rx_slice;
    logic          final_slice;
    logic          bad_step;
  } nhr_res_t;

endpackage

/* design/nhr_if.sv */
// ----------------------------------------------------------------------------
// nhr_if
// Valid/ready request channels: step request in, slice result out.
// ----------------------------------------------------------------------------
interface nhr_in_if;
  logic                      valid;
  logic                      ready;
  logic [nhr_pkg::STEP_W-1:0] step_number;

  modport source(output valid, output step_number, input ready);
  modport sink(input valid, input step_number, output ready);
endinterface

interface nhr_out_if;
  logic                   valid;
  logic                   ready;
  logic [nhr_pkg::FW-1:0] from_rank;
  logic [nhr_pkg::FW-1:0] to_rank;
  logic [nhr_pkg::FW-1:0] slice_count;
  logic [nhr_pkg::FW-1:0] tx_slice;
  logic [nhr_pkg::FW-1:0] rx_slice;
  logic                   final_slice;
  logic                   bad_step;

  modport source(output valid, output from_rank, output to_rank, output slice_count,
                 output tx_slice, output rx_slice, output final_slice, output bad_step,
                 input ready);
  modport sink(input valid, input from_rank, input to_rank, input slice_count,
               input tx_slice, input rx_slice, input final_slice, input bad_step,
               output ready);
endinterface

/* design/nhr_ctrl.sv */
// ----------------------------------------------------------------------------
// nhr_ctrl
// Sequencer: index remainder, distance remainders, peer setup, slice emit.
// ----------------------------------------------------------------------------
module nhr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  nhr_pkg::nhr_sts_t sts,
  output nhr_pkg::nhr_cmd_t cmd
);

  nhr_pkg::nhr_state_t              state_r, state_nxt;
  logic [nhr_pkg::STEP_W-1:0]       cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nhr_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      nhr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = nhr_pkg::ST_ME;
        end
      end
      nhr_pkg::ST_ME: begin
        if (sts.bad) begin
          state_nxt = nhr_pkg::ST_EMIT;
        end else begin
          cmd.rem_shift  = 1'b1;
          cmd.rem_src_me = 1'b1;
          cmd.rem_clr    = (cnt_r == '0);
          if (cnt_r == nhr_pkg::STEP_W'(nhr_pkg::IDX_W - 1)) begin
            state_nxt = nhr_pkg::ST_DINIT;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      nhr_pkg::ST_DINIT: begin
        cmd.save_me   = 1'b1;
        cmd.rem_shift = 1'b1;
        cmd.rem_clr   = 1'b1;
        cmd.rem_one   = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = nhr_pkg::ST_DSHIFT;
      end
      nhr_pkg::ST_DSHIFT: begin
        cmd.rem_shift = 1'b1;
        if (cnt_r == sts.shift) begin
          cmd.save_dmod = 1'b1;
          state_nxt     = nhr_pkg::ST_PEER;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      nhr_pkg::ST_PEER: begin
        cmd.peer  = 1'b1;
        state_nxt = nhr_pkg::ST_EMIT;
      end
      nhr_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) begin
            state_nxt = nhr_pkg::ST_IDLE;
          end else begin
            cmd.next_slice = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = nhr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/nhr_dp.sv */
// ----------------------------------------------------------------------------
// nhr_dp
// Datapath: bit-serial remainder unit, peer and slice index registers.
// ----------------------------------------------------------------------------
module nhr_dp #(
  parameter int MAX_RANKS = 64
) (
  input  logic                       clk,
  input  nhr_pkg::nhr_cmd_t          cmd,
  input  logic [nhr_pkg::STEP_W-1:0] step_number,
  input  logic [nhr_pkg::RS_W-1:0]   rank_size,
  input  logic [nhr_pkg::IDX_W-1:0]  my_index,
  input  logic [nhr_pkg::STEP_W-1:0] step_count,
  output nhr_pkg::nhr_sts_t          sts,
  output nhr_pkg::nhr_res_t          res
);

  localparam int RW = $clog2(MAX_RANKS + 1);
  localparam int CW = (RW > nhr_pkg::RS_W) ? RW : nhr_pkg::RS_W;
  localparam int SW = CW + 1;
  localparam int FW = nhr_pkg::FW;

  logic [RW-1:0]              ring_r, rem_r, me_r, dmod_r, smod_r;
  logic [RW-1:0]              from_r, to_r, tx_r, rx_r;
  logic                       bad_r;
  logic [nhr_pkg::STEP_W-1:0] shift_r;
  logic [nhr_pkg::IDX_W-1:0]  me_sh_r;
  logic [FW-1:0]              n_r, idx_r;

  logic [CW-1:0] rs_w;
  logic [RW-1:0] ring_c, base, rem_nxt, from_c, to_c, tx_c, rx_c;
  logic          rbit;
  logic [RW:0]   rt, fd, ts, txd, rxd, ring_x;
  logic [SW-1:0] dist_w, nsum, nfull;
  logic [FW-1:0] n_c;

  assign rs_w = CW'(rank_size);

  always_comb begin
    if (rs_w == '0) begin
      ring_c = RW'(1);
    end else if (rs_w > CW'(MAX_RANKS)) begin
      ring_c = RW'(MAX_RANKS);
    end else begin
      ring_c = RW'(rs_w);
    end
  end

  // one remainder digit per cycle: rem = (2*rem + bit) mod ring
  assign ring_x  = {1'b0, ring_r};
  assign base    = cmd.rem_clr ? '0 : rem_r;
  assign rbit    = cmd.rem_src_me ? me_sh_r[nhr_pkg::IDX_W-1] : cmd.rem_one;
  assign rt      = {base, rbit};
  assign rem_nxt = (rt >= ring_x) ? RW'(rt - ring_x) : RW'(rt);

  assign fd     = {1'b0, me_r} - {1'b0, dmod_r};
  assign from_c = fd[RW] ? RW'(fd + ring_x) : RW'(fd);
  assign ts     = {1'b0, me_r} + {1'b0, dmod_r};
  assign to_c   = (ts >= ring_x) ? RW'(ts - ring_x) : RW'(ts);
  assign txd    = {1'b0, tx_r} - {1'b0, smod_r};
  assign tx_c   = txd[RW] ? RW'(txd + ring_x) : RW'(txd);
  assign rxd    = {1'b0, rx_r} - {1'b0, smod_r};
  assign rx_c   = rxd[RW] ? RW'(rxd + ring_x) : RW'(rxd);

  assign dist_w = SW'(1) << shift_r;
  assign nsum   = SW'(ring_r) - SW'(1) + dist_w;
  assign nfull  = nsum >> ({1'b0, shift_r} + 4'd1);
  assign n_c    = (nfull > SW'(nhr_pkg::RES_CAP)) ? FW'(nhr_pkg::RES_CAP) : FW'(nfull);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring_r  <= ring_c;
      bad_r   <= (step_number >= step_count);
      shift_r <= step_count - 3'd1 - step_number;
      me_sh_r <= my_index;
    end else if (cmd.rem_shift && cmd.rem_src_me) begin
      me_sh_r <= me_sh_r << 1;
    end
    if (cmd.rem_shift) begin
      rem_r <= rem_nxt;
    end
    if (cmd.save_me) begin
      me_r <= rem_r;
    end
    if (cmd.save_dmod) begin
      dmod_r <= rem_r;
    end
    if (cmd.peer) begin
      smod_r <= rem_r;
      from_r <= from_c;
      to_r   <= to_c;
      n_r    <= n_c;
      idx_r  <= '0;
      tx_r   <= (n_c == '0) ? '0 : me_r;
      rx_r   <= (n_c == '0) ? '0 : from_c;
    end else if (cmd.next_slice) begin
      tx_r  <= tx_c;
      rx_r  <= rx_c;
      idx_r <= idx_r + 1'b1;
    end
  end

  assign sts.bad   = bad_r;
  assign sts.shift = shift_r;
  assign sts.last  = bad_r || (n_r == '0) || (idx_r + 1'b1 == n_r);

  assign res.from_rank   = bad_r ? '0 : FW'(from_r);
  assign res.to_rank     = bad_r ? '0 : FW'(to_r);
  assign res.slice_count = bad_r ? '0 : n_r;
  assign res.tx_slice    = bad_r ? '0 : FW'(tx_r);
  assign res.rx_slice    = bad_r ? '0 : FW'(rx_r);
  assign res.final_slice = sts.last;
  assign res.bad_step    = bad_r;

endmodule

/* design/nhr_step_peer_and_slice_schedule_core.sv */
// ----------------------------------------------------------------------------
// nhr_step_peer_and_slice_schedule_core
// Receive/send peers and slice indices for one ring reduce-scatter step.
// ----------------------------------------------------------------------------
// One step request is handled at a time. A valid step gives n results, one
// per cycle while out_ch.ready is high, where n is the slice count, or one
// when it is zero. The bit-serial remainder unit first reduces my_index
// modulo the ring size, then the same unit gives the distance and the stride
// modulo the ring, and then the peers are set up. A bad step gives a single
// result. Configuration registers: rank_size at 0x0, my_index at 0x4,
// step_count at 0x8; write them only while no request is in flight.
module nhr_step_peer_and_slice_schedule_core #(
  parameter int MAX_RANKS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  nhr_in_if.sink                      in_ch,
  nhr_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nhr_pkg::ADDR_W-1:0]  paddr,
  input  logic [nhr_pkg::DATA_W-1:0]  pwdata,
  output logic [nhr_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [nhr_pkg::RS_W-1:0]   rank_size_r;
  logic [nhr_pkg::IDX_W-1:0]  my_index_r;
  logic [nhr_pkg::STEP_W-1:0] step_count_r;
  nhr_pkg::nhr_reg_t          reg_sel;
  logic                       wr_en;

  nhr_pkg::nhr_cmd_t cmd;
  nhr_pkg::nhr_sts_t sts;
  nhr_pkg::nhr_res_t res;

  assign pready  = 1'b1;
  assign reg_sel = nhr_pkg::nhr_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_size_r  <= nhr_pkg::RS_W'(1);
      my_index_r   <= '0;
      step_count_r <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        nhr_pkg::REG_RANK_SIZE:  rank_size_r  <= pwdata[nhr_pkg::RS_W-1:0];
        nhr_pkg::REG_MY_INDEX:   my_index_r   <= pwdata[nhr_pkg::IDX_W-1:0];
        nhr_pkg::REG_STEP_COUNT: step_count_r <= pwdata[nhr_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      nhr_pkg::REG_RANK_SIZE:  prdata = nhr_pkg::DATA_W'(rank_size_r);
      nhr_pkg::REG_MY_INDEX:   prdata = nhr_pkg::DATA_W'(my_index_r);
      nhr_pkg::REG_STEP_COUNT: prdata = nhr_pkg::DATA_W'(step_count_r);
      default:                 prdata = '0;
    endcase
  end

  nhr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nhr_dp #(
    .MAX_RANKS (MAX_RANKS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .step_number (in_ch.step_number),
    .rank_size   (rank_size_r),
    .my_index    (my_index_r),
    .step_count  (step_count_r),
    .sts         (sts),
    .res         (res)
  );

  assign out_ch.from_rank   = res.from_rank;
  assign out_ch.to_rank     = res.to_rank;
  assign out_ch.slice_count = res.slice_count;
  assign out_ch.tx_slice    = res.tx_slice;
  assign out_ch.rx_slice    = res.rx_slice;
  assign out_ch.final_slice = res.final_slice;
  assign out_ch.bad_step    = res.bad_step;

endmodule

/* design/nhr_sva.sv */
// ----------------------------------------------------------------------------
// nhr_sva
// Port-level checks for the ring step schedule block, bound to the top level.
// ----------------------------------------------------------------------------
module nhr_sva (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [nhr_pkg::FW-1:0] from_rank,
  input logic [nhr_pkg::FW-1:0] slice_count,
  input logic                   final_slice,
  input logic                   bad_step
);

  // one request in flight: no new request while a result is pending
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while result pending");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bad_step |-> final_slice && from_rank == '0 && slice_count == '0)
    else $error("bad step result malformed");

  a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && slice_count == '0 |-> final_slice)
    else $error("empty step not marked final");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> slice_count <= nhr_pkg::FW'(nhr_pkg::RES_CAP))
    else $error("slice count over cap");

  a_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !final_slice |=> out_valid && !in_ready)
    else $error("step ended before final slice");

endmodule

bind nhr_step_peer_and_slice_schedule_core nhr_sva u_nhr_sva (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .from_rank   (out_ch.from_rank),
  .slice_count (out_ch.slice_count),
  .final_slice (out_ch.final_slice),
  .bad_step    (out_ch.bad_step)
);

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Ring step schedule block: peers and slice indices per exchange step.
// Step requests go in over a valid/ready channel and the slice results are
// checked against a local model of the schedule. The registers are set over
// the APB port between phases: extremes, saturation, out-of-ring index,
// distance beyond ring, no-slice steps and bad steps. Random phases use
// varying backpressure.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_MAX   = 64;
  localparam int CYCLE_CAP  = 300000;
  localparam int DRAIN_WAIT = 60;

  class schedule_tracker;
    bit [nhr_pkg::RS_W-1:0]   ring_reg;
    bit [nhr_pkg::IDX_W-1:0]  index_reg;
    bit [nhr_pkg::STEP_W-1:0] steps_reg;
    nhr_pkg::nhr_res_t        due_slices[$];
    int                       errors;
    int                       steps_seen;
    int                       slices_seen;

    function new();
      ring_reg  = 1;
      index_reg = 0;
      steps_reg = 0;
      errors    = 0;
      steps_seen  = 0;
      slices_seen = 0;
    endfunction

    function void expect_slice(nhr_pkg::nhr_res_t r);
      due_slices.insert(due_slices.size(), r);
    endfunction

    function void note_step(bit [nhr_pkg::STEP_W-1:0] step);
      nhr_pkg::nhr_res_t r;
      int ring, me, span, stride, dmod, smod, from, to, n, tx, rx;
      steps_seen++;
      if (step >= steps_reg) begin
        r = '0;
        r.final_slice = 1'b1;
        r.bad_step    = 1'b1;
        expect_slice(r);
        return;
      end
      ring = ring_reg;
      if (ring == 0) ring = 1;
      if (ring > RING_MAX) ring = RING_MAX;
      me     = index_reg % ring;
      span   = 1 << (steps_reg - 1 - step);
      stride = span << 1;
      dmod   = span % ring;
      smod   = stride % ring;
      from   = (me + ring - dmod) % ring;
      to     = (me + dmod) % ring;
      n      = (ring - 1 + span) / stride;
      if (n > nhr_pkg::RES_CAP) n = nhr_pkg::RES_CAP;
      r = '0;
      r.from_rank = from[nhr_pkg::FW-1:0];
      r.to_rank   = to[nhr_pkg::FW-1:0];
      if (n == 0) begin
        r.final_slice = 1'b1;
        expect_slice(r);
        return;
      end
      tx = me;
      rx = from;
      r.slice_count = n[nhr_pkg::FW-1:0];
      for (int i = 0; i < n; i++) begin
        r.tx_slice    = tx[nhr_pkg::FW-1:0];
        r.rx_slice    = rx[nhr_pkg::FW-1:0];
        r.final_slice = (i + 1 == n);
        expect_slice(r);
        tx = (tx + ring - smod) % ring;
        rx = (rx + ring - smod) % ring;
      end
    endfunction

    function void field_ok(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_slice(nhr_pkg::nhr_res_t got);
      nhr_pkg::nhr_res_t want;
      slices_seen++;
      if (due_slices.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        return;
      end
      want = due_slices.pop_front();
      field_ok("from_rank",   want.from_rank,   got.from_rank);
      field_ok("to_rank",     want.to_rank,     got.to_rank);
      field_ok("slice_count", want.slice_count, got.slice_count);
      field_ok("tx_slice",    want.tx_slice,    got.tx_slice);
      field_ok("rx_slice",    want.rx_slice,    got.rx_slice);
      field_ok("final_slice", want.final_slice, got.final_slice);
      field_ok("bad_step",    want.bad_step,    got.bad_step);
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [nhr_pkg::ADDR_W-1:0] paddr;
  logic [nhr_pkg::DATA_W-1:0] pwdata;
  logic [nhr_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  nhr_in_if  in_if();
  nhr_out_if out_if();

  nhr_step_peer_and_slice_schedule_core #(.MAX_RANKS(RING_MAX)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  schedule_tracker tracker = new();
  int tx_idle_pct;
  int rx_idle_pct;
  int cycles = 0;
  int cfg_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("nhr_step_peer_and_slice_schedule_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) tracker.note_step(in_if.step_number);
  end

  always @(posedge clk) begin
    nhr_pkg::nhr_res_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.from_rank   = out_if.from_rank;
      got.to_rank     = out_if.to_rank;
      got.slice_count = out_if.slice_count;
      got.tx_slice    = out_if.tx_slice;
      got.rx_slice    = out_if.rx_slice;
      got.final_slice = out_if.final_slice;
      got.bad_step    = out_if.bad_step;
      tracker.check_slice(got);
    end
  end

  always @(negedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
  end

  task automatic write_reg(nhr_pkg::nhr_reg_t which, int value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {which, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    cfg_writes++;
    case (which)
      nhr_pkg::REG_RANK_SIZE:  tracker.ring_reg  = value[nhr_pkg::RS_W-1:0];
      nhr_pkg::REG_MY_INDEX:   tracker.index_reg = value[nhr_pkg::IDX_W-1:0];
      nhr_pkg::REG_STEP_COUNT: tracker.steps_reg = value[nhr_pkg::STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    while (tracker.due_slices.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_ring(int ring, int index, int steps);
    wait_drain();
    write_reg(nhr_pkg::REG_RANK_SIZE, ring);
    write_reg(nhr_pkg::REG_MY_INDEX, index);
    write_reg(nhr_pkg::REG_STEP_COUNT, steps);
  endtask

  task automatic send_step(int step);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.step_number = step[nhr_pkg::STEP_W-1:0];
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  function automatic int steps_for(int ring);
    int eff, s;
    eff = (ring == 0) ? 1 : (ring > RING_MAX ? RING_MAX : ring);
    s = 0;
    while ((1 << s) < eff) s++;
    return s;
  endfunction

  initial begin
    int ring, index, steps;
    cfg_writes  = 0;
    tx_idle_pct = 27;
    rx_idle_pct = 50;
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_if.valid       = 1'b0;
    in_if.step_number = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset values: every step is bad
    send_step(0);
    send_step(7);

    // full ring, top index, all steps
    set_ring(64, 63, 6);
    for (int s = 0; s < 8; s++) send_step(s);

    // zero ring size, no slices
    set_ring(0, 5, 3);
    for (int s = 0; s < 3; s++) send_step(s);

    // saturated ring, distance equal to ring, stride beyond ring
    set_ring(127, 40, 7);
    for (int s = 0; s < 8; s++) send_step(s);

    // index outside ring
    set_ring(5, 63, 3);
    for (int s = 0; s < 3; s++) send_step(s);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        tx_idle_pct = 50;
        rx_idle_pct = 27;
      end else if (phase == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      ring  = ($urandom_range(3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
      index = ($urandom_range(3) == 0) ? $urandom_range(0, 63)
                                       : $urandom_range(0, steps_for(ring) > 0 ?
                                         (1 << steps_for(ring)) - 1 : 0);
      steps = ($urandom_range(4) == 0) ? $urandom_range(0, 7) : steps_for(ring);
      set_ring(ring, index, steps);
      for (int k = 0; k < 21; k++) begin
        if ($urandom_range(29) == 0) wait_drain();
        if (steps > 0 && $urandom_range(7) != 0) send_step($urandom_range(0, steps - 1));
        else send_step($urandom_range(0, 7));
      end
    end

    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d step requests, %0d slice results, %0d register writes",
             tracker.steps_seen, tracker.slices_seen, cfg_writes);
    $display("ring sizes 0..127, bad steps, empty steps and three backpressure mixes");
    if (tracker.errors == 0 && tracker.due_slices.size() == 0) begin
      $display("nhr_step_peer_and_slice_schedule_core verification clean");
    end else begin
      $display("nhr_step_peer_and_slice_schedule_core verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/nhr_pkg.sv
design/nhr_if.sv
design/nhr_ctrl.sv
design/nhr_dp.sv
design/nhr_step_peer_and_slice_schedule_core.sv
design/nhr_sva.sv
bench/testbench.sv
